// File: rtl/core/qiar_pkg.sv
// ----------------------------------------------------------------------------
// qiar_pkg
// Shared types and constants of the quadrature index angle reporter.
// ----------------------------------------------------------------------------
package qiar_pkg;

  // Pulse counter width (two's complement).
  localparam int CountWidth = 32;
  // mag * 360 fits CountWidth + 8 bits (mag <= 2^(CountWidth-1)).
  localparam int ProdW      = CountWidth + 8;
  // Signed angle in degrees.
  localparam int AngW       = ProdW + 1;
  localparam int DivW       = ProdW;
  localparam int StepW      = $clog2(DivW);
  localparam int DivisorW   = 16;
  // q * 32767 / 360 for q <= 360 as (q * RecipScale) >> RecipShift.
  localparam int ScaleProdW = 33;
  localparam int RecipShift = 17;

  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;

  localparam logic [8:0]          AngleScale = 9'd360;
  localparam logic [14:0]         ValScale   = 15'h7FFF;
  localparam logic [23:0]         RecipScale = 24'd11930101;
  localparam logic [8:0]          SatLimit   = 9'd361;
  localparam logic [15:0]         ValMax     = 16'h7FFF;
  localparam logic [15:0]         ValMin     = 16'h8000;
  localparam logic [7:0]          HdrAngle   = 8'h60;
  localparam logic [7:0]          HdrReady   = 8'hE0;
  localparam logic [7:0]          PadByte    = 8'h00;
  localparam logic [DivisorW-1:0] PprReset   = 16'd200;

  // Register indexes.
  localparam logic [1:0] RegPpr  = 2'd0;
  localparam logic [1:0] RegId   = 2'd1;
  localparam logic [1:0] RegSend = 2'd2;

  // Byte positions of the emitted words: angle frame then ready frame.
  localparam logic [2:0] ByteAngHdr = 3'd0;
  localparam logic [2:0] ByteAngHi  = 3'd1;
  localparam logic [2:0] ByteAngLo  = 3'd2;
  localparam logic [2:0] ByteRdyHdr = 3'd3;
  localparam logic [2:0] ByteRdyId  = 3'd4;
  localparam logic [2:0] ByteRdyVal = 3'd5;
  localparam logic [2:0] ByteRdyPad = 3'd6;

  typedef enum logic [1:0] {
    REQ_A_RISE = 2'd0,
    REQ_A_FALL = 2'd1,
    REQ_INDEX  = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef struct packed {
    logic [DivisorW-1:0] pulses_per_rev;
    logic [4:0]          device_id;
    logic                send_enable;
  } cfg_t;

  typedef struct packed {
    logic       load_angle;
    logic       div_step;
    logic       scale;
    logic       finish;
    logic       emit_load;
    logic [2:0] emit_idx;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic angle_rep;
    logic ready_rep;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/quadrature_index_angle_reporter_core.sv
// Edge and index words: accepted back to back while idle, no output words.
// Report tick: the one-bit-per-cycle restoring divider runs, then one emitted
// word (0..7) is loaded per cycle while the output is not stalled.
// The input is held off until the last word of a tick is loaded.
// Reset (rst, synchronous, active high) clears counter, flags, and config registers.
// ----------------------------------------------------------------------------
// quadrature_index_angle_reporter_core
// Quadrature pulse counter with index; reports angle and ready frames.
// ----------------------------------------------------------------------------
module quadrature_index_angle_reporter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qiar_pkg::ApbAddrW-1:0] paddr,
  input  logic [qiar_pkg::ApbDataW-1:0] pwdata,
  output logic [qiar_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [0] b_level, [7:1] zero
  input  logic [1:0]                    s_tuser,  // [1:0] req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // [7:0] frame_byte
  output logic [1:0]                    m_tuser,  // [0] frame_kind, [1] frame_end
  output logic                          m_tlast   // last word of the tick
);
  import qiar_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_accept;
  logic       kind;
  logic       fend;

  assign in_accept = s_tvalid & s_tready;
  assign m_tuser   = {fend, kind};

  qiar_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qiar_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_req      (s_tuser),
    .in_ready    (s_tready),
    .send_enable (cfg.send_enable),
    .status      (status),
    .cmd         (cmd)
  );

  qiar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_req    (s_tuser),
    .in_b      (s_tdata[0]),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_byte  (m_tdata),
    .out_kind  (kind),
    .out_end   (fend),
    .out_last  (m_tlast)
  );

endmodule

// File: rtl/core/qiar_regs.sv
// ----------------------------------------------------------------------------
// qiar_regs
// APB configuration registers: pulses per revolution, device id, send enable.
// ----------------------------------------------------------------------------
module qiar_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qiar_pkg::ApbAddrW-1:0]       paddr,
  input  logic [qiar_pkg::ApbDataW-1:0]       pwdata,
  output logic [qiar_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready,
  output qiar_pkg::cfg_t                      cfg
);
  import qiar_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_rev <= PprReset;
      cfg.device_id      <= 5'd0;
      cfg.send_enable    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        RegPpr:  cfg.pulses_per_rev <= pwdata[DivisorW-1:0];
        RegId:   cfg.device_id      <= pwdata[4:0];
        RegSend: cfg.send_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegPpr:  prdata = ApbDataW'(cfg.pulses_per_rev);
      RegId:   prdata = ApbDataW'(cfg.device_id);
      RegSend: prdata = ApbDataW'(cfg.send_enable);
      default: prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/qiar_ctrl.sv
// ----------------------------------------------------------------------------
// qiar_ctrl
// Sequencer: angle divide, value scale, report decision, byte emission.
// ----------------------------------------------------------------------------
module qiar_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_req,
  output logic                 in_ready,
  input  logic                 send_enable,
  input  qiar_pkg::dp_status_t status,
  output qiar_pkg::dp_cmd_t    cmd
);
  import qiar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SCALE,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t           state;
  logic [StepW-1:0] cnt;
  logic [2:0]       idx;
  logic [2:0]       last_idx;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_angle = (state == S_MUL);
    cmd.div_step   = (state == S_DIV);
    cmd.scale      = (state == S_SCALE);
    cmd.finish     = (state == S_FINISH);
    cmd.emit_load  = (state == S_EMIT) && status.out_free;
    cmd.emit_idx   = idx;
    cmd.emit_last  = (idx == last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      idx      <= ByteAngHdr;
      last_idx <= ByteAngLo;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && (req_t'(in_req) == REQ_TICK)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          cnt   <= StepW'(DivW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_SCALE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_SCALE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          idx      <= status.angle_rep ? ByteAngHdr : ByteRdyHdr;
          last_idx <= status.ready_rep ? ByteRdyPad : ByteAngLo;
          if (send_enable && (status.angle_rep || status.ready_rep)) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (status.out_free) begin
            if (idx == last_idx) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/qiar_dp.sv
// ----------------------------------------------------------------------------
// qiar_dp
// Pulse counter, restoring divider, value scaling, change detectors, output word.
// ----------------------------------------------------------------------------
module qiar_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  logic [1:0]           in_req,
  input  logic                 in_b,
  input  qiar_pkg::cfg_t       cfg,
  input  qiar_pkg::dp_cmd_t    cmd,
  output qiar_pkg::dp_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_kind,
  output logic                 out_end,
  output logic                 out_last
);
  import qiar_pkg::*;

  logic [CountWidth-1:0] count;
  logic                  abs_ready;
  logic [AngW-1:0]       last_angle;
  logic                  angle_seen;
  logic                  last_ready;
  logic                  ready_seen;
  logic                  angle_rep;
  logic                  ready_rep;

  logic                  neg;
  logic [CountWidth-1:0] mag;
  logic                  sat;
  logic [15:0]           value;

  logic [DivW-1:0]       quo;
  logic [DivisorW-1:0]   rem;
  logic [DivisorW-1:0]   divisor;
  logic [ScaleProdW-1:0] scaled;

  logic [DivisorW:0]     trial;
  logic                  fits;
  logic [ProdW-1:0]      q;
  logic [AngW-1:0]       angle;
  logic                  angle_chg;
  logic [15:0]           m;
  logic [7:0]            byte_sel;

  assign status.angle_rep = angle_rep;
  assign status.ready_rep = ready_rep;
  assign status.out_free  = !out_valid || out_ready;

  assign trial     = {rem, quo[DivW-1]};
  assign fits      = (trial >= {1'b0, divisor});
  assign q         = quo[ProdW-1:0];
  assign angle     = neg ? (AngW'(0) - {1'b0, q}) : {1'b0, q};
  assign angle_chg = !angle_seen || (angle != last_angle);
  assign m         = scaled[RecipShift +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      abs_ready  <= 1'b0;
      last_angle <= '0;
      angle_seen <= 1'b0;
      last_ready <= 1'b0;
      ready_seen <= 1'b0;
      angle_rep  <= 1'b0;
      ready_rep  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        unique case (req_t'(in_req))
          REQ_A_RISE: count <= in_b ? count + CountWidth'(1) : count - CountWidth'(1);
          REQ_A_FALL: count <= in_b ? count - CountWidth'(1) : count + CountWidth'(1);
          REQ_INDEX: begin
            count     <= '0;
            abs_ready <= 1'b1;
          end
          REQ_TICK: ;
          default: ;
        endcase
      end
      if (cmd.scale) begin
        angle_rep  <= angle_chg;
        if (angle_chg) begin
          last_angle <= angle;
          angle_seen <= 1'b1;
        end
        ready_rep  <= !ready_seen || (abs_ready != last_ready);
        last_ready <= abs_ready;
        ready_seen <= 1'b1;
      end
      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (in_accept && (req_t'(in_req) == REQ_TICK)) begin
      neg <= count[CountWidth-1];
      mag <= count[CountWidth-1] ? (CountWidth'(0) - count) : count;
    end
    if (cmd.load_angle) begin
      quo     <= DivW'(ProdW'(mag) * ProdW'(AngleScale));
      rem     <= '0;
      divisor <= (cfg.pulses_per_rev == '0) ? DivisorW'(1) : cfg.pulses_per_rev;
    end else if (cmd.scale) begin
      sat    <= (q >= ProdW'(SatLimit));
      scaled <= ScaleProdW'(q[8:0]) * ScaleProdW'(RecipScale);
    end else if (cmd.div_step) begin
      quo <= {quo[DivW-2:0], fits};
      rem <= fits ? DivisorW'(trial - {1'b0, divisor}) : trial[DivisorW-1:0];
    end
    if (cmd.finish) begin
      if (sat) begin
        value <= neg ? ValMin : ValMax;
      end else begin
        value <= neg ? (16'd0 - m) : m;
      end
    end
    if (cmd.emit_load) begin
      out_byte <= byte_sel;
      out_kind <= (cmd.emit_idx >= ByteRdyHdr);
      out_end  <= (cmd.emit_idx == ByteAngLo) || (cmd.emit_idx == ByteRdyPad);
      out_last <= cmd.emit_last;
    end
  end

  always_comb begin
    unique case (cmd.emit_idx)
      ByteAngHdr: byte_sel = HdrAngle | {3'b000, cfg.device_id};
      ByteAngHi:  byte_sel = value[15:8];
      ByteAngLo:  byte_sel = value[7:0];
      ByteRdyHdr: byte_sel = HdrReady;
      ByteRdyId:  byte_sel = {3'b000, cfg.device_id};
      ByteRdyVal: byte_sel = {7'd0, abs_ready};
      ByteRdyPad: byte_sel = PadByte;
      default:    byte_sel = PadByte;
    endcase
  end

endmodule
